// ===== rtl/core/pffa_pkg.sv =====
// Shared types and codes of the paged first-fit aligned allocator.
package pffa_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EXHAUSTED = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_LIST_FULL = 3'd3;
  localparam logic [2:0] ST_BAD_PAGE  = 3'd4;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_DEALLOC = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_NOFIT,
    S_SHIFT,
    S_SHIFT_WR,
    S_TAIL,
    S_DEALLOC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic next_page;
    logic rd;
    logic next_blk;
    logic take;
    logic shift_rd;
    logic shift_wr;
    logic tail;
    logic fail;
    logic newpg;
    logic dealloc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_dealloc;
    logic p_end;
    logic k_end;
    logic fit;
    logic shift_more;
    logic no_room;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/core/pffa_ctrl.sv =====
// Controller state machine of the allocator: scan, carve, new page, free, emit.
module pffa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pffa_pkg::sts_t  sts,
  output pffa_pkg::cmd_t  cmd
);

  pffa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pffa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      pffa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = pffa_pkg::S_SCAN;
        end
      end
      pffa_pkg::S_SCAN: begin
        if (sts.is_dealloc) begin
          state_nxt = pffa_pkg::S_DEALLOC;
        end else if (sts.p_end) begin
          state_nxt = pffa_pkg::S_NOFIT;
        end else if (sts.k_end) begin
          cmd.next_page = 1'b1;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = pffa_pkg::S_CMP;
        end
      end
      pffa_pkg::S_CMP: begin
        if (sts.fit) begin
          cmd.take  = 1'b1;
          state_nxt = pffa_pkg::S_SHIFT;
        end else begin
          cmd.next_blk = 1'b1;
          state_nxt    = pffa_pkg::S_SCAN;
        end
      end
      pffa_pkg::S_NOFIT: begin
        if (sts.no_room) begin
          cmd.fail  = 1'b1;
          state_nxt = pffa_pkg::S_DONE;
        end else begin
          cmd.newpg = 1'b1;
          state_nxt = pffa_pkg::S_TAIL;
        end
      end
      pffa_pkg::S_SHIFT: begin
        if (sts.shift_more) begin
          cmd.shift_rd = 1'b1;
          state_nxt    = pffa_pkg::S_SHIFT_WR;
        end else begin
          state_nxt = pffa_pkg::S_TAIL;
        end
      end
      pffa_pkg::S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = pffa_pkg::S_SHIFT;
      end
      pffa_pkg::S_TAIL: begin
        cmd.tail  = 1'b1;
        state_nxt = pffa_pkg::S_DONE;
      end
      pffa_pkg::S_DEALLOC: begin
        cmd.dealloc = 1'b1;
        state_nxt   = pffa_pkg::S_DONE;
      end
      pffa_pkg::S_DONE: begin
        // hold the result until the output register is free
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = pffa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pffa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/pffa_dp.sv =====
// Datapath of the allocator: block memory, list counts, scan registers, result.
module pffa_dp #(
  parameter int unsigned MAX_PAGES       = 8,
  parameter int unsigned BLOCKS_PER_PAGE = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  pffa_pkg::cmd_t  cmd,
  output pffa_pkg::sts_t  sts,
  input  logic [31:0]     page_size,
  input  logic            in_func,
  input  logic [31:0]     in_request_size,
  input  logic [4:0]      in_align_log2,
  input  logic [31:0]     in_free_offset_in,
  input  logic [31:0]     in_free_length_in,
  input  logic [2:0]      in_free_page_in,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      out_status,
  output logic [2:0]      out_page_index,
  output logic [31:0]     out_aligned_offset,
  output logic [31:0]     out_granted_size,
  output logic [31:0]     out_handle_offset,
  output logic [31:0]     out_handle_length
);

  localparam int unsigned TOTAL = MAX_PAGES * BLOCKS_PER_PAGE;
  localparam int unsigned AW    = $clog2(TOTAL);
  localparam int unsigned CW    = $clog2(BLOCKS_PER_PAGE + 1);
  localparam int unsigned PGW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned POW   = $clog2(MAX_PAGES + 1);

  function automatic logic [AW-1:0] addr_of(input logic [PGW-1:0] p, input logic [CW-1:0] k);
    addr_of = AW'(AW'(p) * AW'(BLOCKS_PER_PAGE) + AW'(k));
  endfunction

  logic [63:0] mem [TOTAL];
  logic [63:0] rdata_r;
  logic        rd_init_r;
  logic        init0_r;

  logic [CW-1:0]  count_r [MAX_PAGES];
  logic [POW-1:0] pages_open_r;

  logic        func_r;
  logic [32:0] g_r;
  logic [31:0] am1_r;
  logic [31:0] foff_r, flen_r;
  logic [2:0]  fpage_r;

  logic [POW-1:0] p_r;
  logic [CW-1:0]  k_r, j_r, n_r;
  logic [PGW-1:0] fp_r;
  logic [31:0]    s_r, l_r, pad_r;
  logic [33:0]    total_r;

  logic [2:0]  res_status_r, res_page_r;
  logic [31:0] res_aoff_r, res_gsize_r, res_hoff_r, res_hlen_r;
  logic        out_valid_r;
  logic [2:0]  out_status_r, out_page_r;
  logic [31:0] out_aoff_r, out_gsize_r, out_hoff_r, out_hlen_r;

  logic [31:0] am1_in;
  logic [32:0] g_in;
  logic [31:0] rd_s, rd_l, rd_pad;
  logic [33:0] rd_total;
  logic [PGW-1:0] p_idx, dp_idx;
  logic        rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [63:0] wr_data;
  logic        d_bad, d_full;

  assign am1_in = 32'((33'(1) << in_align_log2) - 33'(1));
  assign g_in   = (33'(in_request_size) + 33'(am1_in)) & ~33'(am1_in);

  // entry zero of page zero reads as its reset block until first written
  assign rd_s     = rd_init_r ? 32'd0 : rdata_r[63:32];
  assign rd_l     = rd_init_r ? 32'd65536 : rdata_r[31:0];
  assign rd_pad   = (32'd0 - rd_s) & am1_r;
  assign rd_total = 34'(rd_pad) + 34'(g_r);

  assign p_idx  = PGW'(p_r);
  assign dp_idx = PGW'(fpage_r);
  assign d_bad  = (32'(fpage_r) >= 32'(pages_open_r)) || (32'(fpage_r) >= MAX_PAGES);
  assign d_full = 32'(count_r[dp_idx]) >= BLOCKS_PER_PAGE;

  assign sts.is_dealloc = (func_r == pffa_pkg::FUNC_DEALLOC);
  assign sts.p_end      = (p_r >= pages_open_r);
  assign sts.k_end      = (k_r >= count_r[p_idx]);
  assign sts.fit        = (34'(rd_l) >= rd_total);
  assign sts.shift_more = ((CW+1)'(j_r) + (CW+1)'(1)) < (CW+1)'(n_r);
  assign sts.no_room    = (g_r > 33'(page_size)) || (32'(pages_open_r) >= MAX_PAGES);
  assign sts.out_busy   = out_valid_r && !out_ready;

  always_comb begin
    rd_en   = cmd.rd || cmd.shift_rd;
    rd_addr = cmd.rd ? addr_of(p_idx, k_r) : addr_of(fp_r, CW'(j_r + CW'(1)));
    wr_en   = 1'b0;
    wr_addr = addr_of(fp_r, j_r);
    wr_data = {rd_s, rd_l};
    if (cmd.shift_wr) begin
      wr_en = 1'b1;
    end else if (cmd.tail) begin
      wr_en   = 1'b1;
      wr_addr = addr_of(fp_r, CW'(n_r - CW'(1)));
      wr_data = {32'(34'(s_r) + total_r), 32'(34'(l_r) - total_r)};
    end else if (cmd.dealloc && !d_bad && !d_full) begin
      wr_en   = 1'b1;
      wr_addr = addr_of(dp_idx, count_r[dp_idx]);
      wr_data = {foff_r, flen_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r   <= mem[rd_addr];
      rd_init_r <= init0_r && (rd_addr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init0_r      <= 1'b1;
      pages_open_r <= POW'(1);
      for (int i = 0; i < MAX_PAGES; i++) begin
        count_r[i] <= (i == 0) ? CW'(1) : '0;
      end
    end else begin
      if (wr_en && wr_addr == '0) begin
        init0_r <= 1'b0;
      end
      if (cmd.newpg) begin
        count_r[PGW'(pages_open_r)] <= CW'(1);
        pages_open_r                <= POW'(pages_open_r + POW'(1));
      end
      if (cmd.dealloc && !d_bad && !d_full) begin
        count_r[dp_idx] <= CW'(count_r[dp_idx] + CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      g_r     <= g_in;
      am1_r   <= am1_in;
      foff_r  <= in_free_offset_in;
      flen_r  <= in_free_length_in;
      fpage_r <= in_free_page_in;
      p_r     <= '0;
      k_r     <= '0;
    end
    if (cmd.next_page) begin
      p_r <= POW'(p_r + POW'(1));
      k_r <= '0;
    end
    if (cmd.next_blk) begin
      k_r <= CW'(k_r + CW'(1));
    end
    if (cmd.take) begin
      fp_r    <= p_idx;
      j_r     <= k_r;
      n_r     <= count_r[p_idx];
      s_r     <= rd_s;
      l_r     <= rd_l;
      pad_r   <= rd_pad;
      total_r <= rd_total;
    end
    if (cmd.newpg) begin
      fp_r    <= PGW'(pages_open_r);
      j_r     <= '0;
      n_r     <= CW'(1);
      s_r     <= 32'd0;
      l_r     <= page_size;
      pad_r   <= 32'd0;
      total_r <= 34'(g_r);
    end
    if (cmd.shift_wr) begin
      j_r <= CW'(j_r + CW'(1));
    end
    if (cmd.tail) begin
      res_status_r <= pffa_pkg::ST_OK;
      res_page_r   <= 3'(fp_r);
      res_aoff_r   <= s_r + pad_r;
      res_gsize_r  <= g_r[31:0];
      res_hoff_r   <= s_r;
      res_hlen_r   <= total_r[31:0];
    end
    if (cmd.fail || cmd.dealloc) begin
      res_page_r  <= '0;
      res_aoff_r  <= '0;
      res_gsize_r <= '0;
      res_hoff_r  <= '0;
      res_hlen_r  <= '0;
    end
    if (cmd.fail) begin
      res_status_r <= (g_r > 33'(page_size)) ? pffa_pkg::ST_TOO_LARGE
                                             : pffa_pkg::ST_EXHAUSTED;
    end
    if (cmd.dealloc) begin
      res_status_r <= d_bad ? pffa_pkg::ST_BAD_PAGE
                    : (d_full ? pffa_pkg::ST_LIST_FULL : pffa_pkg::ST_OK);
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_page_r   <= res_page_r;
      out_aoff_r   <= res_aoff_r;
      out_gsize_r  <= res_gsize_r;
      out_hoff_r   <= res_hoff_r;
      out_hlen_r   <= res_hlen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_page_index     = out_page_r;
  assign out_aligned_offset = out_aoff_r;
  assign out_granted_size   = out_gsize_r;
  assign out_handle_offset  = out_hoff_r;
  assign out_handle_length  = out_hlen_r;

endmodule

// ===== rtl/core/paged_first_fit_aligned_allocator.sv =====
// Top level of the paged first-fit aligned allocator.
// Input channel (in_valid/in_ready) takes one allocate or deallocate request
// at a time; in_ready is high only while the controller is idle.
// Output channel (out_valid/out_ready) returns one result per request from an
// output register, so a stalled receiver holds the last result while the next
// request is already being worked on; a finished result then waits until the
// register frees.
// A deallocate steps from scan to the free state and then to done, whose emit raises out_valid.
// An allocate walks the open pages in order, reading each visited block from
// memory and then comparing it for fit, and moves to the next page where a
// list ends; it then moves each list entry after the taken block down, read
// then write, and ends with the shift check, the tail write and the emit.
// Reset clears the lists to one free block [0, 65536) in page zero, one page
// open, page_size 65536. No clearing pass runs: entry zero of page zero reads
// as its reset block until first written, and other entries are only read
// after they are written. page_size is written over the APB port at address 0
// and affects pages opened afterward.
module paged_first_fit_aligned_allocator #(
  parameter int unsigned MAX_PAGES       = 8,
  parameter int unsigned BLOCKS_PER_PAGE = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [31:0] in_request_size,
  input  logic [4:0]  in_align_log2,
  input  logic [31:0] in_free_offset_in,
  input  logic [31:0] in_free_length_in,
  input  logic [2:0]  in_free_page_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [2:0]  out_page_index,
  output logic [31:0] out_aligned_offset,
  output logic [31:0] out_granted_size,
  output logic [31:0] out_handle_offset,
  output logic [31:0] out_handle_length
);

  pffa_pkg::cmd_t cmd;
  pffa_pkg::sts_t sts;
  logic [31:0]    page_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r <= 32'd65536;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      page_size_r <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? page_size_r : 32'd0;

  pffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pffa_dp #(
    .MAX_PAGES       (MAX_PAGES),
    .BLOCKS_PER_PAGE (BLOCKS_PER_PAGE)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .page_size          (page_size_r),
    .in_func            (in_func),
    .in_request_size    (in_request_size),
    .in_align_log2      (in_align_log2),
    .in_free_offset_in  (in_free_offset_in),
    .in_free_length_in  (in_free_length_in),
    .in_free_page_in    (in_free_page_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_page_index     (out_page_index),
    .out_aligned_offset (out_aligned_offset),
    .out_granted_size   (out_granted_size),
    .out_handle_offset  (out_handle_offset),
    .out_handle_length  (out_handle_length)
  );

endmodule

// ===== tb/sv/pffa_grant_checker.sv =====
// Checker: tracks the allocator's free lists, predicts each result and compares.
module pffa_grant_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_func,
  input  logic [31:0] in_request_size,
  input  logic [4:0]  in_align_log2,
  input  logic [31:0] in_free_offset_in,
  input  logic [31:0] in_free_length_in,
  input  logic [2:0]  in_free_page_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [2:0]  out_page_index,
  input  logic [31:0] out_aligned_offset,
  input  logic [31:0] out_granted_size,
  input  logic [31:0] out_handle_offset,
  input  logic [31:0] out_handle_length,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPAGES = 8;
  localparam int NBLK   = 32;
  localparam logic [2:0] ADDR_PAGE_SIZE = 3'd0;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  page;
    logic [31:0] aoff;
    logic [31:0] gsize;
    logic [31:0] hoff;
    logic [31:0] hlen;
  } grant_t;

  grant_t      grant_q[$];
  logic [31:0] blk_start[NPAGES*NBLK];
  logic [31:0] blk_len[NPAGES*NBLK];
  int unsigned blk_cnt[NPAGES];
  int unsigned pages_used;
  logic [31:0] page_bytes;
  int          err_cnt;

  assign mismatches  = err_cnt;
  assign outstanding = grant_q.size();

  function automatic logic [63:0] round_up(input logic [63:0] v, input logic [63:0] a);
    return (v + a - 64'd1) & ~(a - 64'd1);
  endfunction

  // Apply one request to the tracked lists and return the result it yields.
  function automatic grant_t predict_grant(input logic func, input logic [31:0] req,
                                           input logic [4:0] al, input logic [31:0] foff,
                                           input logic [31:0] flen, input logic [2:0] fpg);
    grant_t      r;
    logic [63:0] a, g, s, t, tot, l, ao;
    int          p, k, fp, fk, base, n, j;
    bit          found;
    r = '0;
    if (func == pffa_pkg::FUNC_DEALLOC) begin
      if (fpg >= pages_used) begin
        r.status = pffa_pkg::ST_BAD_PAGE;
      end else if (blk_cnt[fpg] >= NBLK) begin
        r.status = pffa_pkg::ST_LIST_FULL;
      end else begin
        blk_start[fpg*NBLK + blk_cnt[fpg]] = foff;
        blk_len[fpg*NBLK + blk_cnt[fpg]]   = flen;
        blk_cnt[fpg]++;
      end
      return r;
    end
    a = 64'd1 << al;
    g = round_up({32'd0, req}, a);
    found = 0;
    fp = 0;
    fk = 0;
    tot = '0;
    for (p = 0; p < pages_used && !found; p++) begin
      for (k = 0; k < blk_cnt[p] && !found; k++) begin
        s = {32'd0, blk_start[p*NBLK + k]};
        t = round_up(s, a) - s + g;
        if ({32'd0, blk_len[p*NBLK + k]} >= t) begin
          found = 1;
          fp = p;
          fk = k;
          tot = t;
        end
      end
    end
    if (!found) begin
      if (g > {32'd0, page_bytes}) begin
        r.status = pffa_pkg::ST_TOO_LARGE;
      end else if (pages_used >= NPAGES) begin
        r.status = pffa_pkg::ST_EXHAUSTED;
      end else begin
        fp = pages_used;
        blk_start[fp*NBLK] = '0;
        blk_len[fp*NBLK]   = page_bytes;
        blk_cnt[fp] = 1;
        pages_used++;
        fk = 0;
        tot = g;
        found = 1;
      end
    end
    if (found) begin
      base = fp * NBLK;
      n = blk_cnt[fp];
      s = {32'd0, blk_start[base + fk]};
      l = {32'd0, blk_len[base + fk]};
      ao = round_up(s, a);
      r.page  = fp[2:0];
      r.aoff  = ao[31:0];
      r.gsize = g[31:0];
      r.hoff  = s[31:0];
      r.hlen  = tot[31:0];
      // close the gap, then append the remainder at the tail
      for (j = fk; j + 1 < n; j++) begin
        blk_start[base + j] = blk_start[base + j + 1];
        blk_len[base + j]   = blk_len[base + j + 1];
      end
      blk_start[base + n - 1] = s[31:0] + tot[31:0];
      blk_len[base + n - 1]   = l[31:0] - tot[31:0];
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v, inout bit bad);
    if (exp_v !== act_v) begin
      bad = 1;
      if (err_cnt < 10)
        $display("%0t mismatch %s: expected %h got %h", $realtime, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    grant_t exp_g;
    bit     bad;
    if (!rst_n) begin
      grant_q.delete();
      for (int i = 0; i < NPAGES*NBLK; i++) begin
        blk_start[i] = '0;
        blk_len[i] = '0;
      end
      for (int i = 0; i < NPAGES; i++) blk_cnt[i] = 0;
      page_bytes = 32'd65536;
      blk_len[0] = page_bytes;
      blk_cnt[0] = 1;
      pages_used = 1;
      err_cnt = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_PAGE_SIZE)
        page_bytes = pwdata;
      if (in_valid && in_ready)
        grant_q.insert(grant_q.size(),
                       predict_grant(in_func, in_request_size, in_align_log2,
                                     in_free_offset_in, in_free_length_in,
                                     in_free_page_in));
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          if (err_cnt < 10) $display("%0t result transfer with nothing expected", $realtime);
          err_cnt++;
        end else begin
          exp_g = grant_q.pop_front();
          bad = 0;
          check_field("status", 32'(exp_g.status), 32'(out_status), bad);
          check_field("page_index", 32'(exp_g.page), 32'(out_page_index), bad);
          check_field("aligned_offset", exp_g.aoff, out_aligned_offset, bad);
          check_field("granted_size", exp_g.gsize, out_granted_size, bad);
          check_field("handle_offset", exp_g.hoff, out_handle_offset, bad);
          check_field("handle_length", exp_g.hlen, out_handle_length, bad);
          if (bad) err_cnt++;
        end
      end
    end
  end

endmodule

// ===== tb/sv/paged_first_fit_aligned_allocator_tb.sv =====
// Testbench top: clock, reset, APB setup, request stimulus and verdict.
module paged_first_fit_aligned_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_func = pffa_pkg::FUNC_ALLOC;
  logic [31:0] in_request_size = '0;
  logic [4:0]  in_align_log2 = '0;
  logic [31:0] in_free_offset_in = '0;
  logic [31:0] in_free_length_in = '0;
  logic [2:0]  in_free_page_in = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  out_status, out_page_index;
  logic [31:0] out_aligned_offset, out_granted_size, out_handle_offset, out_handle_length;
  int          mismatches, outstanding;

  localparam logic [2:0] ADDR_PAGE_SIZE = 3'd0;

  typedef struct packed {
    logic [2:0]  page;
    logic [31:0] offset;
    logic [31:0] length;
  } handle_t;

  handle_t live_handles[$];
  bit      no_idle = 0;
  bit      hold_req = 0;

  always #4 clk = ~clk;

  paged_first_fit_aligned_allocator u_top (.*);

  pffa_grant_checker u_chk (.*);

  // collect granted blocks so they can be handed back later
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready && out_status == pffa_pkg::ST_OK
        && out_handle_length != 0 && live_handles.size() < 64)
      live_handles.insert(live_handles.size(),
                          handle_t'({out_page_index, out_handle_offset, out_handle_length}));
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 0;
        repeat (400) @(posedge clk);
      end
      out_ready <= no_idle || ($urandom_range(0, 99) >= 32);
    end
  end

  task automatic write_page_size(input logic [31:0] v);
    psel <= 1;
    pwrite <= 1;
    paddr <= ADDR_PAGE_SIZE;
    pwdata <= v;
    penable <= 0;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic send(input logic func, input logic [31:0] req, input logic [4:0] al,
                      input logic [31:0] foff, input logic [31:0] flen,
                      input logic [2:0] fpg);
    in_valid <= 1;
    in_func <= func;
    in_request_size <= req;
    in_align_log2 <= al;
    in_free_offset_in <= foff;
    in_free_length_in <= flen;
    in_free_page_in <= fpg;
    do @(posedge clk); while (!in_ready);
    if (!no_idle && $urandom_range(0, 99) < 32) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_alloc(input logic [31:0] req, input logic [4:0] al);
    send(pffa_pkg::FUNC_ALLOC, req, al, $urandom, $urandom, 3'($urandom_range(0, 7)));
  endtask

  task automatic send_free(input logic [31:0] foff, input logic [31:0] flen,
                           input logic [2:0] fpg);
    send(pffa_pkg::FUNC_DEALLOC, $urandom, 5'($urandom_range(0, 31)), foff, flen, fpg);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_item();
    int      pick, idx;
    handle_t h;
    pick = $urandom_range(0, 99);
    if (pick < 75 && pick >= 45 && live_handles.size() != 0) begin
      idx = $urandom_range(0, live_handles.size() - 1);
      h = live_handles[idx];
      live_handles.delete(idx);
      send_free(h.offset, h.length, h.page);
    end else if (pick < 75) begin
      send_alloc($urandom_range(0, 200),
                 5'(($urandom_range(0, 99) < 10) ? $urandom_range(0, 31)
                                                 : $urandom_range(0, 6)));
    end else if (pick < 85) begin
      send_alloc($urandom, 5'($urandom_range(0, 31)));
    end else begin
      send_free($urandom, $urandom, 3'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    logic [31:0] sizes[5];
    sizes = '{32'd0, 32'd256, 32'hFFFF_FFFF, 32'd1, 32'd0};
    sizes[4] = $urandom_range(16, 4096);
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed corners under the reset page size
    send_alloc(32'd0, 5'd0);
    send_alloc(32'd1, 5'd0);
    send_alloc(32'd100, 5'd4);
    send_alloc(32'hFFFF_FFFF, 5'd0);
    send_alloc(32'hFFFF_FFFF, 5'd31);
    send_alloc(32'd1, 5'd31);
    send_alloc(32'd65536, 5'd0);
    send_alloc(32'd65536, 5'd16);
    send_free(32'd0, 32'd1, 3'd7);
    send_free(32'd64, 32'd32, 3'd0);
    send_free(32'hFFFF_FFF0, 32'hFFFF_FFFF, 3'd1);
    send_alloc(32'd40, 5'd3);
    send_alloc(32'd1000, 5'd10);
    send_free(32'hFFFF_FFFF, 32'd0, 3'd0);
    send_alloc(32'd0, 5'd31);
    send_free(32'd0, 32'd0, 3'd2);
    drain();

    foreach (sizes[ph]) begin
      write_page_size(sizes[ph]);
      no_idle = (ph == 2);
      for (int i = 0; i < 320; i++) begin
        if (ph == 1 && i == 100) hold_req = 1;
        random_item();
      end
      drain();
    end
    no_idle = 0;

    repeat (50) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("paged_first_fit_aligned_allocator_tb: PASS");
    else
      $display("paged_first_fit_aligned_allocator_tb: FAIL");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("paged_first_fit_aligned_allocator_tb: FAIL");
    $finish;
  end

endmodule

// ===== paged_first_fit_aligned_allocator.f =====
rtl/core/pffa_pkg.sv
rtl/core/pffa_ctrl.sv
rtl/core/pffa_dp.sv
rtl/core/paged_first_fit_aligned_allocator.sv
tb/sv/pffa_grant_checker.sv
tb/sv/paged_first_fit_aligned_allocator_tb.sv
